FILE: sv/wav_stream_parser_defines.svh
// assertion macros used by the wav stream parser rtl
`ifndef WAV_STREAM_PARSER_DEFINES_SVH
`define WAV_STREAM_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define WSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wav stream parser check failed");

`define WSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wav stream parser reset check failed");

`else

`define WSP_ASSERT(lbl, prop)

`define WSP_ASSERT_RST(lbl, prop)

`endif

`endif

FILE: sv/wsp_pkg.sv
// types and constants of the wav stream parser
`default_nettype none

package wsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef enum logic [3:0] {
    PH_RIFF_TAG   = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_TAG   = 4'd2,
    PH_CHUNK_TAG  = 4'd3,
    PH_CHUNK_SIZE = 4'd4,
    PH_FMT        = 4'd5,
    PH_DATA       = 4'd6,
    PH_SKIP       = 4'd7,
    PH_PAD        = 4'd8,
    PH_END_PEND   = 4'd9,
    PH_DONE       = 4'd10,
    PH_ERROR      = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_BAD_TAG = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/wav_stream_parser.sv
// riff/wave byte stream parser giving 16-bit pcm sample pairs
// usage:
//   input channel: one file byte per word on in_byte, with in_file_start high
//   on the first byte of a file to restart the parser. a word is taken when
//   in_valid is high and in_stall is low.
//   output channel: at most one result word per input byte: a sample pair,
//   a bad tag error or end of riff data, along with the fmt chunk fields.
//   taken when out_valid is high and out_stall is low.
// timing:
//   a taken byte passes through the input register, then its result is held
//   in the result register on the outputs. one byte per cycle sustained while
//   out_stall is low; the parse state updates once per byte. bytes that give
//   no result still pass through the input register.
// reset:
//   rst_n low clears both stages and the parse state (expect riff tag).
// stall:
//   while out_stall holds a waiting result, the input register keeps its byte
//   and in_stall rises once it is full; nothing is dropped.
`default_nettype none
`include "wav_stream_parser_defines.svh"

module wav_stream_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_file_start,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [1:0]         out_result_kind,
  output      logic signed [15:0] out_left_sample,
  output      logic signed [15:0] out_right_sample,
  output      logic [15:0]        out_channels,
  output      logic [31:0]        out_sample_rate,
  output      logic [15:0]        out_bits_per_sample
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;
  logic       adv;

  // parse state
  wsp_pkg::phase_t phase_r, phase_nxt, phase_c;
  logic [1:0]  idx_r, idx_nxt, idx_c;
  logic [31:0] riff_left_r, riff_left_nxt, riff_left_c;
  logic [31:0] chunk_left_r, chunk_left_nxt, chunk_left_c;
  logic [31:0] chunk_tag_r, chunk_tag_nxt, chunk_tag_c;
  logic [31:0] acc_r, acc_nxt, acc_c;
  logic [4:0]  fmt_off_r, fmt_off_nxt, fmt_off_c;
  logic [15:0] format_code_r, format_code_nxt, format_code_c;
  logic [15:0] chan_r, chan_nxt, chan_c;
  logic [31:0] rate_r, rate_nxt, rate_c;
  logic [15:0] bits_r, bits_nxt, bits_c;
  logic [23:0] frame_r, frame_nxt, frame_c;
  logic [1:0]  frame_cnt_r, frame_cnt_nxt, frame_cnt_c;
  logic        pad_r, pad_nxt, pad_c;

  // result register
  logic               out_valid_r;
  wsp_pkg::kind_t     out_kind_r;
  logic signed [15:0] out_left_r, out_right_r;
  logic [15:0]        out_chan_r, out_bits_r;
  logic [31:0]        out_rate_r;

  // per-byte results
  logic           res_vld;
  wsp_pkg::kind_t res_kind;
  logic [15:0]    res_left, res_right;
  logic           counts;
  logic           body;
  logic [31:0]    tag_ref;
  logic [31:0]    b_ext;
  logic [4:0]     sh;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_start_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
      s1_start_r <= in_file_start;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
    end
  end

  // next parse state for the byte in the input register
  always_comb begin
    phase_c     = s1_start_r ? wsp_pkg::PH_RIFF_TAG : phase_r;
    idx_c       = s1_start_r ? 2'd0  : idx_r;
    riff_left_c = s1_start_r ? 32'd0 : riff_left_r;
    chunk_left_c = s1_start_r ? 32'd0 : chunk_left_r;
    chunk_tag_c = s1_start_r ? 32'd0 : chunk_tag_r;
    acc_c       = s1_start_r ? 32'd0 : acc_r;
    fmt_off_c   = s1_start_r ? 5'd0  : fmt_off_r;
    format_code_c = s1_start_r ? 16'd0 : format_code_r;
    chan_c      = s1_start_r ? 16'd0 : chan_r;
    rate_c      = s1_start_r ? 32'd0 : rate_r;
    bits_c      = s1_start_r ? 16'd0 : bits_r;
    frame_c     = s1_start_r ? 24'd0 : frame_r;
    frame_cnt_c = s1_start_r ? 2'd0  : frame_cnt_r;
    pad_c       = s1_start_r ? 1'b0  : pad_r;

    phase_nxt       = phase_c;
    idx_nxt         = idx_c;
    riff_left_nxt   = riff_left_c;
    chunk_left_nxt  = chunk_left_c;
    chunk_tag_nxt   = chunk_tag_c;
    acc_nxt         = acc_c;
    fmt_off_nxt     = fmt_off_c;
    format_code_nxt = format_code_c;
    chan_nxt        = chan_c;
    rate_nxt        = rate_c;
    bits_nxt        = bits_c;
    frame_nxt       = frame_c;
    frame_cnt_nxt   = frame_cnt_c;
    pad_nxt         = pad_c;

    res_vld   = 1'b0;
    res_kind  = wsp_pkg::KIND_SAMPLE;
    res_left  = 16'd0;
    res_right = 16'd0;
    body      = 1'b0;

    counts  = (phase_c >= wsp_pkg::PH_WAVE_TAG) && (phase_c <= wsp_pkg::PH_PAD);
    tag_ref = (phase_c == wsp_pkg::PH_RIFF_TAG) ? wsp_pkg::TAG_RIFF : wsp_pkg::TAG_WAVE;
    b_ext   = {24'd0, s1_byte_r};
    sh      = {idx_c, 3'b000};

    unique case (phase_c)
      wsp_pkg::PH_RIFF_TAG, wsp_pkg::PH_WAVE_TAG: begin
        if (s1_byte_r != tag_ref[sh +: 8]) begin
          res_vld  = 1'b1;
          res_kind = wsp_pkg::KIND_BAD_TAG;
        end else if (idx_c == 2'd3) begin
          idx_nxt = 2'd0;
          acc_nxt = 32'd0;
          if (phase_c == wsp_pkg::PH_RIFF_TAG) begin
            phase_nxt = wsp_pkg::PH_RIFF_SIZE;
          end else begin
            phase_nxt     = wsp_pkg::PH_CHUNK_TAG;
            chunk_tag_nxt = 32'd0;
          end
        end else begin
          idx_nxt = idx_c + 2'd1;
        end
      end
      wsp_pkg::PH_RIFF_SIZE: begin
        acc_nxt = acc_c | (b_ext << sh);
        if (idx_c == 2'd3) begin
          idx_nxt       = 2'd0;
          riff_left_nxt = acc_nxt;
          if (acc_nxt == 32'd0) begin
            res_vld   = 1'b1;
            res_kind  = wsp_pkg::KIND_END;
            phase_nxt = wsp_pkg::PH_DONE;
          end else begin
            phase_nxt = wsp_pkg::PH_WAVE_TAG;
          end
        end else begin
          idx_nxt = idx_c + 2'd1;
        end
      end
      wsp_pkg::PH_CHUNK_TAG: begin
        chunk_tag_nxt = chunk_tag_c | (b_ext << sh);
        if (idx_c == 2'd3) begin
          idx_nxt   = 2'd0;
          acc_nxt   = 32'd0;
          phase_nxt = wsp_pkg::PH_CHUNK_SIZE;
        end else begin
          idx_nxt = idx_c + 2'd1;
        end
      end
      wsp_pkg::PH_CHUNK_SIZE: begin
        acc_nxt = acc_c | (b_ext << sh);
        if (idx_c == 2'd3) begin
          idx_nxt        = 2'd0;
          chunk_left_nxt = acc_nxt;
          pad_nxt        = acc_nxt[0];
          acc_nxt        = 32'd0;
          if (chunk_left_nxt == 32'd0) begin
            phase_nxt     = wsp_pkg::PH_CHUNK_TAG;
            chunk_tag_nxt = 32'd0;
          end else if (chunk_tag_c == wsp_pkg::TAG_FMT) begin
            format_code_nxt = 16'd0;
            chan_nxt        = 16'd0;
            rate_nxt        = 32'd0;
            bits_nxt        = 16'd0;
            fmt_off_nxt     = 5'd0;
            phase_nxt       = wsp_pkg::PH_FMT;
          end else if (chunk_tag_c == wsp_pkg::TAG_DATA) begin
            frame_nxt     = 24'd0;
            frame_cnt_nxt = 2'd0;
            phase_nxt     = wsp_pkg::PH_DATA;
          end else begin
            phase_nxt = wsp_pkg::PH_SKIP;
          end
        end else begin
          idx_nxt = idx_c + 2'd1;
        end
      end
      wsp_pkg::PH_FMT: begin
        // byte offset inside the fmt body picks the field
        if (fmt_off_c < 5'd2) begin
          format_code_nxt = format_code_c |
                            (16'(s1_byte_r) << {fmt_off_c[0], 3'b000});
        end else if (fmt_off_c < 5'd4) begin
          chan_nxt = chan_c | (16'(s1_byte_r) << {fmt_off_c[0], 3'b000});
        end else if (fmt_off_c < 5'd8) begin
          rate_nxt = rate_c | (b_ext << {fmt_off_c[1:0], 3'b000});
        end else if (fmt_off_c >= 5'd14 && fmt_off_c < 5'd16) begin
          bits_nxt = bits_c | (16'(s1_byte_r) << {fmt_off_c[0], 3'b000});
        end
        if (fmt_off_c < 5'd16) begin
          fmt_off_nxt = fmt_off_c + 5'd1;
        end
        body = 1'b1;
      end
      wsp_pkg::PH_DATA: begin
        if (chan_c == 16'd1) begin
          if (frame_cnt_c == 2'd0) begin
            frame_nxt     = {16'd0, s1_byte_r};
            frame_cnt_nxt = 2'd1;
          end else begin
            res_vld       = 1'b1;
            res_left      = {s1_byte_r, frame_c[7:0]};
            res_right     = res_left;
            frame_nxt     = 24'd0;
            frame_cnt_nxt = 2'd0;
          end
        end else if (frame_cnt_c < 2'd3) begin
          frame_nxt     = frame_c | (24'(s1_byte_r) << {frame_cnt_c, 3'b000});
          frame_cnt_nxt = frame_cnt_c + 2'd1;
        end else begin
          res_vld       = 1'b1;
          res_left      = frame_c[15:0];
          res_right     = {s1_byte_r, frame_c[23:16]};
          frame_nxt     = 24'd0;
          frame_cnt_nxt = 2'd0;
        end
        body = 1'b1;
      end
      wsp_pkg::PH_SKIP: begin
        body = 1'b1;
      end
      wsp_pkg::PH_PAD: begin
        phase_nxt     = wsp_pkg::PH_CHUNK_TAG;
        idx_nxt       = 2'd0;
        chunk_tag_nxt = 32'd0;
      end
      wsp_pkg::PH_END_PEND: begin
        res_vld   = 1'b1;
        res_kind  = wsp_pkg::KIND_END;
        phase_nxt = wsp_pkg::PH_DONE;
      end
      default: begin
      end
    endcase

    // one byte of a chunk body used up
    if (body) begin
      chunk_left_nxt = chunk_left_c - 32'(chunk_left_c != 32'd0);
      if (chunk_left_nxt == 32'd0) begin
        if (pad_c) begin
          phase_nxt = wsp_pkg::PH_PAD;
        end else begin
          phase_nxt     = wsp_pkg::PH_CHUNK_TAG;
          idx_nxt       = 2'd0;
          chunk_tag_nxt = 32'd0;
        end
      end
    end

    // riff size bookkeeping; a pair on the last byte defers the end word
    if (res_vld && res_kind == wsp_pkg::KIND_BAD_TAG) begin
      phase_nxt = wsp_pkg::PH_ERROR;
    end else if (counts) begin
      riff_left_nxt = riff_left_c - 32'(riff_left_c != 32'd0);
      if (riff_left_nxt == 32'd0) begin
        if (res_vld) begin
          phase_nxt = wsp_pkg::PH_END_PEND;
        end else begin
          res_vld   = 1'b1;
          res_kind  = wsp_pkg::KIND_END;
          phase_nxt = wsp_pkg::PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= wsp_pkg::PH_RIFF_TAG;
      idx_r         <= 2'd0;
      riff_left_r   <= 32'd0;
      chunk_left_r  <= 32'd0;
      chunk_tag_r   <= 32'd0;
      acc_r         <= 32'd0;
      fmt_off_r     <= 5'd0;
      format_code_r <= 16'd0;
      chan_r        <= 16'd0;
      rate_r        <= 32'd0;
      bits_r        <= 16'd0;
      frame_r       <= 24'd0;
      frame_cnt_r   <= 2'd0;
      pad_r         <= 1'b0;
    end else if (adv) begin
      phase_r       <= phase_nxt;
      idx_r         <= idx_nxt;
      riff_left_r   <= riff_left_nxt;
      chunk_left_r  <= chunk_left_nxt;
      chunk_tag_r   <= chunk_tag_nxt;
      acc_r         <= acc_nxt;
      fmt_off_r     <= fmt_off_nxt;
      format_code_r <= format_code_nxt;
      chan_r        <= chan_nxt;
      rate_r        <= rate_nxt;
      bits_r        <= bits_nxt;
      frame_r       <= frame_nxt;
      frame_cnt_r   <= frame_cnt_nxt;
      pad_r         <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_vld;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_kind_r  <= res_kind;
      out_left_r  <= res_left;
      out_right_r <= res_right;
      out_chan_r  <= chan_nxt;
      out_rate_r  <= rate_nxt;
      out_bits_r  <= bits_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_left_sample     = out_left_r;
  assign out_right_sample    = out_right_r;
  assign out_channels        = out_chan_r;
  assign out_sample_rate     = out_rate_r;
  assign out_bits_per_sample = out_bits_r;

  `WSP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r)
  `WSP_ASSERT(a_kind_range, out_valid_r |-> out_kind_r != 2'd3)
  `WSP_ASSERT(a_non_sample_zero,
    out_valid_r && out_kind_r != wsp_pkg::KIND_SAMPLE |->
      out_left_r == 16'sd0 && out_right_r == 16'sd0)
  `WSP_ASSERT(a_silent_after_end,
    adv && res_vld && !s1_start_r |->
      phase_r != wsp_pkg::PH_DONE && phase_r != wsp_pkg::PH_ERROR)
  `WSP_ASSERT(a_end_pend_riff_empty,
    phase_r == wsp_pkg::PH_END_PEND |-> riff_left_r == 32'd0)

endmodule

`default_nettype wire

FILE: sim/wav_stream_parser_tb.sv
// self-checking testbench for the wav stream parser: directed rows, then random wav files
`timescale 1ns / 100ps

module wav_stream_parser_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_BYTES   = 700;

  typedef struct packed {
    wsp_pkg::kind_t     kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        chans;
    logic [31:0]        rate;
    logic [15:0]        bits;
  } parse_word_t;

  typedef struct {
    logic [7:0]  val;
    bit          st;
    bit          typed;
    parse_word_t want;
  } step_row_t;

  localparam parse_word_t NO_WORD   = '0;
  localparam parse_word_t BAD_BLANK =
    '{wsp_pkg::KIND_BAD_TAG, 16'sd0, 16'sd0, 16'd0, 32'd0, 16'd0};
  localparam parse_word_t END_BLANK =
    '{wsp_pkg::KIND_END, 16'sd0, 16'sd0, 16'd0, 32'd0, 16'd0};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_byte = 8'd0;
  logic               in_file_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_result_kind;
  logic signed [15:0] out_left_sample;
  logic signed [15:0] out_right_sample;
  logic [15:0]        out_channels;
  logic [31:0]        out_sample_rate;
  logic [15:0]        out_bits_per_sample;

  wav_stream_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte             (in_byte),
    .in_file_start       (in_file_start),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_left_sample     (out_left_sample),
    .out_right_sample    (out_right_sample),
    .out_channels        (out_channels),
    .out_sample_rate     (out_sample_rate),
    .out_bits_per_sample (out_bits_per_sample)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state as the testbench sees it
  wsp_pkg::phase_t wp_phase;
  logic [1:0]  wp_idx;
  logic [31:0] riff_left;
  logic [31:0] chunk_left;
  logic [31:0] chunk_tag_acc;
  logic [31:0] field_acc;
  logic [15:0] fmt_code;
  logic [15:0] fmt_channels;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic [23:0] frame_acc;
  logic [1:0]  frame_cnt;
  bit          pad_due;

  parse_word_t pending_words[$];
  logic [7:0]  file_bytes[$];
  bit          file_starts[$];
  step_row_t   directed_rows[25];
  int          mismatches = 0;
  bit          calm = 1'b0;

  function automatic void wav_reset();
    wp_phase      = wsp_pkg::PH_RIFF_TAG;
    wp_idx        = '0;
    riff_left     = '0;
    chunk_left    = '0;
    chunk_tag_acc = '0;
    field_acc     = '0;
    fmt_code      = '0;
    fmt_channels  = '0;
    fmt_rate      = '0;
    fmt_bits      = '0;
    frame_acc     = '0;
    frame_cnt     = '0;
    pad_due       = 1'b0;
  endfunction

  function automatic void begin_chunk_header();
    wp_phase      = wsp_pkg::PH_CHUNK_TAG;
    wp_idx        = '0;
    chunk_tag_acc = '0;
  endfunction

  function automatic void consume_body_byte();
    if (chunk_left != 0) chunk_left = chunk_left - 1;
    if (chunk_left == 0) begin
      if (pad_due) wp_phase = wsp_pkg::PH_PAD;
      else begin_chunk_header();
    end
  endfunction

  // advances the parser by one byte; returns 1 when the byte yields a result word
  function automatic bit parse_byte(input logic [7:0] b, input bit restart,
                                    output parse_word_t word);
    bit                 hit;
    bit                 counted;
    wsp_pkg::kind_t     k;
    logic signed [15:0] lft;
    logic signed [15:0] rgt;
    logic [31:0]        tag;
    logic [31:0]        off;
    hit = 1'b0;
    k   = wsp_pkg::KIND_SAMPLE;
    lft = '0;
    rgt = '0;
    if (restart) wav_reset();
    counted = (wp_phase >= wsp_pkg::PH_WAVE_TAG) && (wp_phase <= wsp_pkg::PH_PAD);
    case (wp_phase)
      wsp_pkg::PH_RIFF_TAG, wsp_pkg::PH_WAVE_TAG: begin
        tag = (wp_phase == wsp_pkg::PH_RIFF_TAG) ? wsp_pkg::TAG_RIFF : wsp_pkg::TAG_WAVE;
        if (b != tag[8*wp_idx +: 8]) begin
          hit = 1'b1;
          k   = wsp_pkg::KIND_BAD_TAG;
        end else if (wp_idx == 2'd3) begin
          wp_idx    = '0;
          field_acc = '0;
          if (wp_phase == wsp_pkg::PH_RIFF_TAG) wp_phase = wsp_pkg::PH_RIFF_SIZE;
          else begin_chunk_header();
        end else begin
          wp_idx = wp_idx + 2'd1;
        end
      end
      wsp_pkg::PH_RIFF_SIZE: begin
        field_acc |= 32'(b) << (8 * wp_idx);
        if (wp_idx == 2'd3) begin
          wp_idx    = '0;
          riff_left = field_acc;
          if (riff_left == 0) begin
            hit      = 1'b1;
            k        = wsp_pkg::KIND_END;
            wp_phase = wsp_pkg::PH_DONE;
          end else begin
            wp_phase = wsp_pkg::PH_WAVE_TAG;
          end
        end else begin
          wp_idx = wp_idx + 2'd1;
        end
      end
      wsp_pkg::PH_CHUNK_TAG: begin
        chunk_tag_acc |= 32'(b) << (8 * wp_idx);
        if (wp_idx == 2'd3) begin
          wp_idx    = '0;
          field_acc = '0;
          wp_phase  = wsp_pkg::PH_CHUNK_SIZE;
        end else begin
          wp_idx = wp_idx + 2'd1;
        end
      end
      wsp_pkg::PH_CHUNK_SIZE: begin
        field_acc |= 32'(b) << (8 * wp_idx);
        if (wp_idx == 2'd3) begin
          wp_idx     = '0;
          chunk_left = field_acc;
          pad_due    = field_acc[0];
          field_acc  = '0;
          if (chunk_left == 0) begin
            begin_chunk_header();
          end else if (chunk_tag_acc == wsp_pkg::TAG_FMT) begin
            fmt_code     = '0;
            fmt_channels = '0;
            fmt_rate     = '0;
            fmt_bits     = '0;
            wp_phase     = wsp_pkg::PH_FMT;
          end else if (chunk_tag_acc == wsp_pkg::TAG_DATA) begin
            frame_acc = '0;
            frame_cnt = '0;
            wp_phase  = wsp_pkg::PH_DATA;
          end else begin
            wp_phase = wsp_pkg::PH_SKIP;
          end
        end else begin
          wp_idx = wp_idx + 2'd1;
        end
      end
      wsp_pkg::PH_FMT: begin
        // field_acc doubles as the byte offset inside the fmt body
        off = field_acc;
        if (off < 2) fmt_code |= 16'(b) << (8 * off);
        else if (off < 4) fmt_channels |= 16'(b) << (8 * (off - 2));
        else if (off < 8) fmt_rate |= 32'(b) << (8 * (off - 4));
        else if (off >= 14 && off < 16) fmt_bits |= 16'(b) << (8 * (off - 14));
        if (off < 16) field_acc = off + 1;
        consume_body_byte();
      end
      wsp_pkg::PH_DATA: begin
        if (fmt_channels == 16'd1) begin
          if (frame_cnt == 2'd0) begin
            frame_acc = 24'(b);
            frame_cnt = 2'd1;
          end else begin
            lft       = {b, frame_acc[7:0]};
            rgt       = lft;
            hit       = 1'b1;
            frame_acc = '0;
            frame_cnt = '0;
          end
        end else if (frame_cnt < 2'd3) begin
          frame_acc |= 24'(b) << (8 * frame_cnt);
          frame_cnt = frame_cnt + 2'd1;
        end else begin
          lft       = frame_acc[15:0];
          rgt       = {b, frame_acc[23:16]};
          hit       = 1'b1;
          frame_acc = '0;
          frame_cnt = '0;
        end
        consume_body_byte();
      end
      wsp_pkg::PH_SKIP: consume_body_byte();
      wsp_pkg::PH_PAD: begin_chunk_header();
      wsp_pkg::PH_END_PEND: begin
        hit      = 1'b1;
        k        = wsp_pkg::KIND_END;
        wp_phase = wsp_pkg::PH_DONE;
      end
      default: ;
    endcase

    if (hit && k == wsp_pkg::KIND_BAD_TAG) begin
      wp_phase = wsp_pkg::PH_ERROR;
    end else if (counted) begin
      if (riff_left != 0) riff_left = riff_left - 1;
      if (riff_left == 0) begin
        // a pair finishing on the last byte holds the end word back by one byte
        if (hit) begin
          wp_phase = wsp_pkg::PH_END_PEND;
        end else begin
          hit      = 1'b1;
          k        = wsp_pkg::KIND_END;
          wp_phase = wsp_pkg::PH_DONE;
        end
      end
    end

    word = '{k, lft, rgt, fmt_channels, fmt_rate, fmt_bits};
    return hit;
  endfunction

  task automatic push_le32(ref logic [7:0] q[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
  endtask

  // builds one wav file (sometimes broken, sometimes plain noise) into file_bytes
  task automatic build_file();
    logic [7:0]   body[$];
    logic [7:0]   hdr[$];
    logic [7:0]   b;
    logic [31:0]  sz;
    logic [31:0]  riff_sz;
    logic [127:0] fmt_img;
    int           n_chunks;
    int           sel;
    int           emit;
    if ($urandom_range(0, 11) == 0) begin
      n_chunks = $urandom_range(1, 6);
      for (int i = 0; i < n_chunks; i++) begin
        file_bytes.push_back(8'($urandom));
        file_starts.push_back(i == 0 || $urandom_range(0, 7) == 0);
      end
    end else begin
      body = '{8'h57, 8'h41, 8'h56, 8'h45};
      n_chunks = $urandom_range(1, 4);
      for (int c = 0; c < n_chunks; c++) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
          push_le32(body, wsp_pkg::TAG_FMT);
          sz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 16;
          push_le32(body, sz);
          fmt_img = {$urandom, $urandom, $urandom, $urandom};
          if ($urandom_range(0, 1)) fmt_img[15:0] = 16'd1;
          case ($urandom_range(0, 7))
            0, 1, 2: fmt_img[31:16] = 16'd1;
            3, 4:    fmt_img[31:16] = 16'd2;
            5:       fmt_img[31:16] = 16'h0000;
            6:       fmt_img[31:16] = 16'hFFFF;
            default: ;
          endcase
          if ($urandom_range(0, 1)) fmt_img[127:112] = 16'd16;
          for (int i = 0; i < sz; i++) body.push_back(i < 16 ? fmt_img[8*i +: 8] : 8'($urandom));
          if (sz[0]) body.push_back(8'($urandom));
        end else if (sel < 8) begin
          push_le32(body, wsp_pkg::TAG_DATA);
          sz = $urandom_range(0, 24);
          push_le32(body, sz);
          for (int i = 0; i < sz; i++) begin
            case ($urandom_range(0, 7))
              0:       b = 8'h00;
              1:       b = 8'hFF;
              2:       b = 8'h80;
              3:       b = 8'h7F;
              default: b = 8'($urandom);
            endcase
            body.push_back(b);
          end
          if (sz[0]) body.push_back(8'($urandom));
        end else begin
          push_le32(body, $urandom);
          if ($urandom_range(0, 3) == 0) begin
            // huge declared size, only the riff size ends this file
            sz   = $urandom;
            emit = $urandom_range(0, 6);
          end else begin
            sz   = $urandom_range(0, 6);
            emit = sz + sz[0];
          end
          push_le32(body, sz);
          for (int i = 0; i < emit; i++) body.push_back(8'($urandom));
        end
      end

      case ($urandom_range(0, 9))
        0:       riff_sz = $urandom_range(0, body.size());
        1:       riff_sz = body.size() + $urandom_range(1, 6);
        default: riff_sz = body.size();
      endcase
      hdr = '{8'h52, 8'h49, 8'h46, 8'h46};
      push_le32(hdr, riff_sz);
      case ($urandom_range(0, 19))
        0:       hdr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        1:       body[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
        default: ;
      endcase
      hdr = {hdr, body};
      for (int i = 0; i < $urandom_range(0, 2); i++) hdr.push_back(8'($urandom));
      foreach (hdr[i]) begin
        file_bytes.push_back(hdr[i]);
        file_starts.push_back(i == 0);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit st, input bit typed,
                           input parse_word_t want);
    parse_word_t word;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    in_file_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_byte(b, st, word)) begin
      if (typed) word = want;
      pending_words.push_back(word);
    end
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_words.size() != 0);
  endtask

  task automatic report_word(input string what, input parse_word_t want, input parse_word_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at %0t: expected kind=%0d l=%0d r=%0d ch=%0d rate=%0d bits=%0d",
               what, $realtime, want.kind, want.left, want.right, want.chans, want.rate,
               want.bits);
    if (mismatches <= 10)
      $display("    got kind=%0d l=%0d r=%0d ch=%0d rate=%0d bits=%0d",
               seen.kind, seen.left, seen.right, seen.chans, seen.rate, seen.bits);
  endtask

  always @(posedge clk) begin
    parse_word_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{wsp_pkg::kind_t'(out_result_kind), out_left_sample, out_right_sample,
               out_channels, out_sample_rate, out_bits_per_sample};
      if (pending_words.size() == 0) report_word("no word pending", NO_WORD, seen);
      else if (seen !== pending_words[0]) report_word("field", pending_words.pop_front(), seen);
      else void'(pending_words.pop_front());
    end
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 13);
  end

  // counts cycles with no word moving on either side
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sent;
    bit paused;
    wav_reset();
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, BAD_BLANK},  // wrong first tag byte straight after reset
      '{8'hFF, 1'b0, 1'b0, NO_WORD},    // ignored after a tag error
      '{8'h52, 1'b1, 1'b0, NO_WORD},
      '{8'h49, 1'b0, 1'b0, NO_WORD},
      '{8'h46, 1'b0, 1'b0, NO_WORD},
      '{8'h46, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, END_BLANK},  // riff size of zero ends on the last size byte
      '{8'h52, 1'b0, 1'b0, NO_WORD},    // ignored after the end
      '{8'h52, 1'b1, 1'b0, NO_WORD},
      '{8'h49, 1'b0, 1'b0, NO_WORD},
      '{8'h46, 1'b0, 1'b0, NO_WORD},
      '{8'h46, 1'b0, 1'b0, NO_WORD},
      '{8'h05, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h57, 1'b0, 1'b0, NO_WORD},
      '{8'h41, 1'b0, 1'b0, NO_WORD},
      '{8'h56, 1'b0, 1'b0, NO_WORD},
      '{8'h45, 1'b0, 1'b0, NO_WORD},
      '{8'h80, 1'b0, 1'b1, END_BLANK},  // riff size used up on a chunk tag byte
      '{8'h7F, 1'b0, 1'b0, NO_WORD}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].val, directed_rows[i].st, directed_rows[i].typed,
                directed_rows[i].want);
    drain_pending();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_BYTES) begin
      calm = (sent >= 250 && sent < 400);
      build_file();
      while (file_bytes.size() != 0) begin
        send_byte(file_bytes.pop_front(), file_starts.pop_front(), 1'b0, NO_WORD);
        sent++;
      end
      if (!paused && sent >= 450) begin
        drain_pending();
        paused = 1'b1;
      end
    end
    calm = 1'b0;

    drain_pending();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
